### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/vgd_pkg.sv
// ----------------------------------------------------------------------------
// vgd_pkg
// shared types and constants of the voxel grid downsampler
// ----------------------------------------------------------------------------
package vgd_pkg;
  localparam int TableEntries = 64;
  localparam int MaxPointsPerCell = 65535;
  localparam int IdxW = $clog2(TableEntries);
  localparam int UsedW = $clog2(TableEntries + 1);
  localparam int SumW = 48;
  localparam int CntW = 16;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // one table entry as it travels along the chain
  typedef struct packed {
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] sz;
    logic [CntW-1:0] cnt;
  } entry_t;

  // control that every cell sees
  typedef struct packed {
    logic match_en;  // compare against search key
    logic upd;       // add point into matching cell
    logic ins;       // write new entry into selected cell
    logic shift;     // move entries one cell toward the head
    logic [IdxW-1:0] ins_idx;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cell_ctl_t;
endpackage

### rtl/vgd_cell.sv
// ----------------------------------------------------------------------------
// vgd_cell
// one voxel entry: key compare, accumulate, and hand-off to the previous cell
// ----------------------------------------------------------------------------
module vgd_cell import vgd_pkg::*; (
  input  logic                clk,
  input  logic [IdxW-1:0]     idx,
  input  cell_ctl_t           ctl,
  input  entry_t              from_next,
  output entry_t              ent,
  output logic                hit
);
  entry_t ent_next;

  assign hit = ctl.match_en && ent.kx == ctl.kx && ent.ky == ctl.ky && ent.kz == ctl.kz;

  always_comb begin
    ent_next = ent;
    if (ctl.shift) begin
      ent_next = from_next;
    end else if (ctl.ins && ctl.ins_idx == idx) begin
      ent_next.kx = ctl.kx;
      ent_next.ky = ctl.ky;
      ent_next.kz = ctl.kz;
      ent_next.sx = SumW'(ctl.px);
      ent_next.sy = SumW'(ctl.py);
      ent_next.sz = SumW'(ctl.pz);
      ent_next.cnt = CntW'(1);
    end else if (ctl.upd && hit) begin
      ent_next.sx = ent.sx + SumW'(ctl.px);
      ent_next.sy = ent.sy + SumW'(ctl.py);
      ent_next.sz = ent.sz + SumW'(ctl.pz);
      ent_next.cnt = ent.cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end
endmodule

### rtl/vgd_div.sv
// ----------------------------------------------------------------------------
// vgd_div
// sequential floor divider, one quotient bit per cycle, signed dividend
// ----------------------------------------------------------------------------
module vgd_div import vgd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SumW-1:0]  dividend,
  input  logic [31:0]             divisor,
  output logic                    busy,
  output logic signed [SumW-1:0]  quot
);
  localparam int CntBits = $clog2(SumW + 1);
  logic [SumW-1:0] mag;
  logic [SumW-1:0] mag_next;
  logic [32:0] rem;
  logic [32:0] rem_next;
  logic [31:0] dvs;
  logic neg;
  logic [CntBits-1:0] cnt;
  logic [32:0] trial;
  logic [SumW-1:0] qpos;

  assign trial = {rem[31:0], mag[SumW-1]} - {1'b0, dvs};

  always_comb begin
    mag_next = {mag[SumW-2:0], 1'b0};
    rem_next = {rem[31:0], mag[SumW-1]};
    if (!trial[32]) begin
      rem_next = trial;
      mag_next[0] = 1'b1;
    end
  end

  // floor for negative: -(q) or -(q+1) when remainder nonzero
  assign qpos = mag;
  assign quot = neg ? (rem != 33'd0 ? ~qpos : -qpos) : qpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntBits'(SumW);
    end else if (busy) begin
      cnt <= cnt - CntBits'(1);
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SumW-1];
      mag <= dividend[SumW-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end
endmodule

### rtl/voxel_grid_downsampler.sv
// ----------------------------------------------------------------------------
// voxel_grid_downsampler
// voxel grid centroid downsampling over a chain of table cells
// ----------------------------------------------------------------------------
// channel  | direction | signals
// in       | input     | in_valid, in_stall, cmd, point_x/y/z
// out      | output    | out_valid, out_stall, out_x/y/z, points_merged, last, overflow
// cfg      | apb       | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// add point: three serial key divisions on the shared bit-serial
// divider (each: start, 48 steps, collect), then a parallel key
// compare across the cells. pass-through add when the voxel edge is zero.
// flush: per voxel, three serial divisions and one output transfer;
// entries leave the head by shifting.
// reset clears the fill count, the drop flag and the voxel edge; entries are not.
// a stalled result holds in the output register and the block waits.
`include "assert_macros.svh"
module voxel_grid_downsampler import vgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [15:0]        points_merged,
  output logic               last,
  output logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_KEY   = 8'b0000_0010,
    S_MATCH = 8'b0000_0100,
    S_FDIV  = 8'b0000_1000,
    S_FOUT  = 8'b0001_0000,
    S_OUT   = 8'b0010_0000,
    S_KWAIT = 8'b0100_0000,
    S_FWAIT = 8'b1000_0000
  } state_t;

  state_t state;
  logic [30:0] vox_edge;
  logic [UsedW-1:0] used;
  logic dropped;
  logic [1:0] axis;
  logic signed [31:0] px, py, pz;
  logic [31:0] kx, ky, kz;
  logic flush_ovf;
  logic [UsedW-1:0] left;

  entry_t ents [TableEntries];
  logic [TableEntries-1:0] hits;
  cell_ctl_t ctl;
  entry_t tail_in;

  logic div_start, div_busy;
  logic signed [SumW-1:0] div_a, div_q;
  logic [31:0] div_b;

  assign pready = 1'b1;
  assign prdata = paddr == 1'b0 ? {1'b0, vox_edge} : 32'd0;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vox_edge <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      vox_edge <= pwdata[30:0];
    end
  end

  assign tail_in = ents[TableEntries-1];

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    vgd_cell u_cell (
      .clk      (clk),
      .idx      (IdxW'(g)),
      .ctl      (ctl),
      .from_next(g == TableEntries - 1 ? tail_in : ents[(g + 1) % TableEntries]),
      .ent      (ents[g]),
      .hit      (hits[g])
    );
  end

  vgd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_a),
    .divisor (div_b),
    .busy    (div_busy),
    .quot    (div_q)
  );

  logic any_hit, hit_full;
  always_comb begin
    any_hit = 1'b0;
    hit_full = 1'b0;
    for (int i = 0; i < TableEntries; i++) begin
      if (hits[i] && UsedW'(i) < used) begin
        any_hit = 1'b1;
        if (ents[i].cnt == CntW'(MaxPointsPerCell)) hit_full = 1'b1;
      end
    end
  end

  always_comb begin
    ctl = '0;
    ctl.kx = kx;
    ctl.ky = ky;
    ctl.kz = kz;
    ctl.px = px;
    ctl.py = py;
    ctl.pz = pz;
    ctl.ins_idx = used[IdxW-1:0];
    ctl.match_en = 1'b1;
    if (state == S_MATCH) begin
      ctl.upd = any_hit && !hit_full;
      ctl.ins = !any_hit && used < UsedW'(TableEntries);
    end
    if (state == S_FOUT && !out_stall && out_valid) ctl.shift = 1'b1;
  end

  always_comb begin
    div_start = 1'b0;
    div_a = SumW'(px);
    div_b = {1'b0, vox_edge};
    if (state == S_KEY && !div_busy) begin
      div_start = 1'b1;
      unique case (axis)
        2'd0: div_a = SumW'(px);
        2'd1: div_a = SumW'(py);
        default: div_a = SumW'(pz);
      endcase
    end else if (state == S_FDIV && !div_busy) begin
      div_start = 1'b1;
      div_b = 32'(ents[0].cnt);
      unique case (axis)
        2'd0: div_a = ents[0].sx;
        2'd1: div_a = ents[0].sy;
        default: div_a = ents[0].sz;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      dropped <= 1'b0;
      out_valid <= 1'b0;
      axis <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px <= point_x;
            py <= point_y;
            pz <= point_z;
            axis <= '0;
            if (cmd == CmdFlush) begin
              flush_ovf <= dropped;
              dropped <= 1'b0;
              left <= used;
              if (used != '0) state <= S_FDIV;
            end else if (vox_edge == '0) begin
              out_x <= point_x;
              out_y <= point_y;
              out_z <= point_z;
              points_merged <= 16'd1;
              last <= 1'b1;
              overflow <= dropped;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_KEY;
            end
          end
        end
        S_KEY: state <= S_KWAIT;
        S_KWAIT: begin
          if (!div_busy) begin
            unique case (axis)
              2'd0: kx <= div_q[31:0];
              2'd1: ky <= div_q[31:0];
              default: kz <= div_q[31:0];
            endcase
            if (axis == 2'd2) begin
              state <= S_MATCH;
            end else begin
              axis <= axis + 2'd1;
              state <= S_KEY;
            end
          end
        end
        S_MATCH: begin
          if (any_hit) begin
            if (hit_full) dropped <= 1'b1;
          end else if (used < UsedW'(TableEntries)) begin
            used <= used + UsedW'(1);
          end else begin
            dropped <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_FDIV: state <= S_FWAIT;
        S_FWAIT: begin
          if (!div_busy) begin
            unique case (axis)
              2'd0: out_x <= div_q[31:0];
              2'd1: out_y <= div_q[31:0];
              default: out_z <= div_q[31:0];
            endcase
            if (axis == 2'd2) begin
              axis <= '0;
              points_merged <= ents[0].cnt;
              last <= left == UsedW'(1);
              overflow <= flush_ovf;
              out_valid <= 1'b1;
              state <= S_FOUT;
            end else begin
              axis <= axis + 2'd1;
              state <= S_FDIV;
            end
          end
        end
        S_FOUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            left <= left - UsedW'(1);
            if (left == UsedW'(1)) begin
              used <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_FDIV;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_used_range, 1'b1, used <= UsedW'(TableEntries))
  `ASSERT_IMP(a_valid_state, out_valid, state == S_OUT || state == S_FOUT)
  `ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_x))
endmodule
